// ===== rtl/wfs_pkg.sv =====
// shared types, constants and helpers for the weighted fifo semaphore
package wfs_pkg;

  // sizing of the waiter queue and the available count
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned COUNT_BITS  = 32;

  // fixed field widths
  localparam int unsigned CFG_BITS   = 32;
  localparam int unsigned CMD_BITS   = 2;
  localparam int unsigned TID_BITS   = 8;
  localparam int unsigned CNT_BITS   = 16;
  localparam int unsigned CODE_BITS  = 2;
  localparam int unsigned ENTRY_BITS = TID_BITS + CNT_BITS;

  // derived widths
  localparam int unsigned IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned OCC_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_BITS = ((COUNT_BITS > CNT_BITS) ? COUNT_BITS : CNT_BITS) + 1;

  // saturation limit of the available count, in compare width
  localparam logic [CMP_BITS-1:0] COUNT_MAX =
    (CMP_BITS'(1) << COUNT_BITS) - CMP_BITS'(1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_WAIT         = 2'd0,
    CMD_SIGNAL_ONE   = 2'd1,
    CMD_SIGNAL_COUNT = 2'd2,
    CMD_CLOSE        = 2'd3
  } wfs_cmd_e;

  typedef enum logic [CODE_BITS-1:0] {
    CODE_OK      = 2'd0,
    CODE_BLOCKED = 2'd1,
    CODE_CLOSED  = 2'd2,
    CODE_FULL    = 2'd3
  } wfs_code_e;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_EXEC   = 3'd1,
    OP_STATUS = 3'd2,
    OP_POP    = 3'd3,
    OP_WEMIT  = 3'd4
  } wfs_op_e;

  typedef struct packed {
    logic    latch;
    wfs_op_e op;
    logic    last;
  } wfs_ctrl_t;

  typedef struct packed {
    logic exec_emits;
    logic signal_one;
    logic head_fits;
    logic slot_free;
  } wfs_status_t;

  // queue index increment with wrap at the depth
  function automatic logic [IDX_BITS-1:0] idx_inc(input logic [IDX_BITS-1:0] idx);
    return (idx == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_BITS'(1);
  endfunction

endpackage

// ===== rtl/wfs_ram.sv =====
// generic single write port ram with registered read
module wfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/wfs_datapath.sv =====
// semaphore datapath: count, flags, queue pointers, waiter ram and output register
module wfs_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wfs_pkg::CFG_BITS-1:0]   cfg_wdata_i,
  input  logic [wfs_pkg::CMD_BITS-1:0]   in_cmd_i,
  input  logic [wfs_pkg::TID_BITS-1:0]   in_thread_id_i,
  input  logic [wfs_pkg::CNT_BITS-1:0]   in_count_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic                           out_kind_o,
  output logic [wfs_pkg::TID_BITS-1:0]   out_target_thread_o,
  output logic [wfs_pkg::CODE_BITS-1:0]  out_code_o,
  output logic                           out_last_o,
  input  wfs_pkg::wfs_ctrl_t             ctrl_i,
  output wfs_pkg::wfs_status_t           status_o
);
  import wfs_pkg::*;

  // latched input item
  wfs_cmd_e              cmd_q, cmd_d;
  logic [TID_BITS-1:0]   tid_q, tid_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;

  // semaphore state
  logic [COUNT_BITS-1:0] avail_q, avail_d;
  logic                  closed_q, closed_d;
  logic [IDX_BITS-1:0]   head_q, head_d;
  logic [IDX_BITS-1:0]   tail_q, tail_d;
  logic [OCC_BITS-1:0]   occ_q, occ_d;

  // popped waiter waiting to go out
  logic [TID_BITS-1:0]   pend_tid_q, pend_tid_d;
  wfs_code_e             pend_code_q, pend_code_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic                  out_kind_q, out_kind_d;
  logic [TID_BITS-1:0]   out_tid_q, out_tid_d;
  wfs_code_e             out_code_q, out_code_d;
  logic                  out_last_q, out_last_d;

  // waiter ram
  logic                  ram_we;
  logic [ENTRY_BITS-1:0] ram_rdata;
  logic [TID_BITS-1:0]   head_tid;
  logic [CNT_BITS-1:0]   head_cnt;

  // compare-width operands
  logic [CMP_BITS-1:0]   wide_avail, wide_cnt, wide_head, add_amt, sum;
  logic                  wait_pass, queue_full, head_fits;

  // emitted item
  logic                  emit;
  logic                  e_kind;
  logic [TID_BITS-1:0]   e_tid;
  wfs_code_e             e_code;

  assign head_tid   = ram_rdata[ENTRY_BITS-1:CNT_BITS];
  assign head_cnt   = ram_rdata[CNT_BITS-1:0];
  assign wide_avail = CMP_BITS'(avail_q);
  assign wide_cnt   = CMP_BITS'(cnt_q);
  assign wide_head  = CMP_BITS'(head_cnt);
  assign add_amt    = (cmd_q == CMD_SIGNAL_ONE) ? CMP_BITS'(1) : wide_cnt;
  assign sum        = wide_avail + add_amt;

  assign wait_pass  = (occ_q == '0) && (wide_avail >= wide_cnt);
  assign queue_full = (occ_q == OCC_BITS'(QUEUE_DEPTH));
  assign head_fits  = (occ_q != '0) && (closed_q || (wide_head <= wide_avail));

  // status for the controller
  assign status_o.exec_emits = closed_q || (cmd_q == CMD_WAIT);
  assign status_o.signal_one = (cmd_q == CMD_SIGNAL_ONE);
  assign status_o.head_fits  = head_fits;
  assign status_o.slot_free  = !out_valid_q || !out_stall_i;

  // next-state logic
  always_comb begin
    cmd_d       = cmd_q;
    tid_d       = tid_q;
    cnt_d       = cnt_q;
    avail_d     = avail_q;
    closed_d    = closed_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    pend_tid_d  = pend_tid_q;
    pend_code_d = pend_code_q;
    ram_we      = 1'b0;
    emit        = 1'b0;
    e_kind      = 1'b0;
    e_tid       = tid_q;
    e_code      = CODE_OK;

    // input transfer
    if (ctrl_i.latch) begin
      cmd_d = wfs_cmd_e'(in_cmd_i);
      tid_d = in_thread_id_i;
      cnt_d = in_count_i;
    end

    unique case (ctrl_i.op)
      OP_EXEC: begin
        if (closed_q) begin
          emit   = 1'b1;
          e_code = CODE_CLOSED;
        end else begin
          unique case (cmd_q)
            CMD_WAIT: begin
              emit = 1'b1;
              if (wait_pass) begin
                avail_d = COUNT_BITS'(wide_avail - wide_cnt);
                e_code  = CODE_OK;
              end else if (queue_full) begin
                e_code  = CODE_FULL;
              end else begin
                ram_we  = 1'b1;
                tail_d  = idx_inc(tail_q);
                occ_d   = occ_q + OCC_BITS'(1);
                e_code  = CODE_BLOCKED;
              end
            end
            CMD_SIGNAL_ONE, CMD_SIGNAL_COUNT: begin
              // saturating add
              avail_d = (sum > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(sum);
            end
            CMD_CLOSE: begin
              closed_d = 1'b1;
            end
          endcase
        end
      end
      OP_STATUS: begin
        emit   = 1'b1;
        e_code = CODE_OK;
      end
      OP_POP: begin
        pend_tid_d  = head_tid;
        pend_code_d = closed_q ? CODE_CLOSED : CODE_OK;
        head_d      = idx_inc(head_q);
        occ_d       = occ_q - OCC_BITS'(1);
        if (!closed_q) begin
          avail_d = COUNT_BITS'(wide_avail - wide_head);
        end
      end
      OP_WEMIT: begin
        emit   = 1'b1;
        e_kind = 1'b1;
        e_tid  = pend_tid_q;
        e_code = pend_code_q;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase

    // register write loads the count
    if (cfg_we_i) begin
      avail_d = COUNT_BITS'(cfg_wdata_i);
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_tid_d   = out_tid_q;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = e_kind;
      out_tid_d   = e_tid;
      out_code_d  = e_code;
      out_last_d  = ctrl_i.last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q     <= '0;
      closed_q    <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      avail_q     <= avail_d;
      closed_q    <= closed_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    tid_q       <= tid_d;
    cnt_q       <= cnt_d;
    pend_tid_q  <= pend_tid_d;
    pend_code_q <= pend_code_d;
    out_kind_q  <= out_kind_d;
    out_tid_q   <= out_tid_d;
    out_code_q  <= out_code_d;
    out_last_q  <= out_last_d;
  end

  // waiter queue; read address follows the next head so the data tracks the head
  wfs_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i ({tid_q, cnt_q}),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = out_kind_q;
  assign out_target_thread_o = out_tid_q;
  assign out_code_o          = out_code_q;
  assign out_last_o          = out_last_q;

endmodule

// ===== rtl/wfs_ctrl.sv =====
// semaphore controller: sequences execute, caller status and waiter release
module wfs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  wfs_pkg::wfs_status_t status_i,
  output wfs_pkg::wfs_ctrl_t   ctrl_o
);
  import wfs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_STATUS = 5'b00100,
    ST_POP    = 5'b01000,
    ST_WEMIT  = 5'b10000
  } wfs_state_e;

  wfs_state_e state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // state transitions and datapath commands
  always_comb begin
    state_d      = state_q;
    ctrl_o.latch = accept;
    ctrl_o.op    = OP_NONE;
    ctrl_o.last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.exec_emits) begin
          // wait or closed: single caller status
          if (status_i.slot_free) begin
            ctrl_o.op   = OP_EXEC;
            ctrl_o.last = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          ctrl_o.op = OP_EXEC;
          state_d   = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (status_i.slot_free) begin
          ctrl_o.op   = OP_STATUS;
          ctrl_o.last = !status_i.head_fits;
          state_d     = status_i.head_fits ? ST_POP : ST_IDLE;
        end
      end
      ST_POP: begin
        ctrl_o.op = OP_POP;
        state_d   = ST_WEMIT;
      end
      ST_WEMIT: begin
        // signal one releases at most the head
        if (status_i.slot_free) begin
          ctrl_o.op   = OP_WEMIT;
          ctrl_o.last = !status_i.head_fits || status_i.signal_one;
          state_d     = (status_i.head_fits && !status_i.signal_one) ? ST_POP : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/weighted_fifo_semaphore.sv =====
// top level of the weighted fifo counting semaphore
//
// Input channel (in_valid_i / in_stall_o) carries one command: wait for a count,
// signal one, signal a count, or close. Output channel (out_valid_o / out_stall_i)
// carries result items: first the caller's status, then wake-ups of released
// waiters in queue order; out_last_o marks the final item of a command.
// One command is in flight at a time. A wait, or any command on a closed
// semaphore, gives a single result. Signal and close give the caller status,
// then wake-ups of released waiters through the pop / emit loop over the
// registered read of the waiter ram.
// The result sits in an output register; while the receiver stalls the sequencer
// holds before its next emit. Signal updates the count and close sets the closed
// flag before the caller status goes out, and each pop (ST_POP) comes ahead of
// its wake-up emit (ST_WEMIT).
// cfg_we_i loads cfg_wdata_i into the available count; write it only while idle.
// Reset clears the count to zero, opens the semaphore and empties the queue;
// ram contents stay undefined and are only read once written.
module weighted_fifo_semaphore (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wfs_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wfs_pkg::CMD_BITS-1:0]  in_cmd_i,
  input  logic [wfs_pkg::TID_BITS-1:0]  in_thread_id_i,
  input  logic [wfs_pkg::CNT_BITS-1:0]  in_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_kind_o,
  output logic [wfs_pkg::TID_BITS-1:0]  out_target_thread_o,
  output logic [wfs_pkg::CODE_BITS-1:0] out_code_o,
  output logic                          out_last_o
);
  import wfs_pkg::*;

  wfs_ctrl_t   ctrl;
  wfs_status_t status;

  wfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  wfs_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_cmd_i            (in_cmd_i),
    .in_thread_id_i      (in_thread_id_i),
    .in_count_i          (in_count_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .out_kind_o          (out_kind_o),
    .out_target_thread_o (out_target_thread_o),
    .out_code_o          (out_code_o),
    .out_last_o          (out_last_o),
    .ctrl_i              (ctrl),
    .status_o            (status)
  );

  // an input transfer always makes the block busy in the next cycle
  a_busy_after_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input transfer did not make the block busy");

  // status and wake-up emits only go out when the output slot is free
  a_emit_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_STATUS || ctrl.op == OP_WEMIT) |-> status.slot_free)
    else $error("result emitted into an occupied output register");

  // a pop is only issued for a queued head that may leave
  a_pop_head_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_POP) |-> status.head_fits)
    else $error("waiter popped that does not fit or queue empty");

  // after a pop the block stays busy for the wake-up item that the pop prepared
  a_wemit_after_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_POP) |=> !in_stall_o == 1'b0)
    else $error("block went idle between pop and wake-up");

endmodule

// ===== verif/wfs_checker.sv =====
// predictor and result check for the weighted fifo semaphore, watching both channels
`timescale 1ns / 1ps

module wfs_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wfs_pkg::CFG_BITS-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [wfs_pkg::CMD_BITS-1:0]   in_cmd_i,
  input  logic [wfs_pkg::TID_BITS-1:0]   in_thread_id_i,
  input  logic [wfs_pkg::CNT_BITS-1:0]   in_count_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           out_kind_i,
  input  logic [wfs_pkg::TID_BITS-1:0]   out_target_thread_i,
  input  logic [wfs_pkg::CODE_BITS-1:0]  out_code_i,
  input  logic                           out_last_i,
  output int                             pending_o,
  output int                             errors_o
);
  import wfs_pkg::*;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WAKE   = 1'b1;
  localparam int   MAX_REPORTS = 10;

  typedef struct packed {
    logic [TID_BITS-1:0] tid;
    logic [CNT_BITS-1:0] units;
  } waiter_t;

  typedef struct packed {
    logic                kind;
    logic [TID_BITS-1:0] tid;
    wfs_code_e           code;
    logic                last;
  } reply_t;

  // predicted semaphore state
  logic [COUNT_BITS-1:0] avail_units = '0;
  logic                  sem_closed  = 1'b0;
  waiter_t               blocked_waiters[$];
  reply_t                replies_due[$];
  int                    fail_count  = 0;

  // work out every reply that one command causes, caller status first
  task automatic predict_replies(input wfs_cmd_e cmd, input logic [TID_BITS-1:0] tid,
                                 input logic [CNT_BITS-1:0] units);
    logic [COUNT_BITS:0] sum;
    waiter_t             head;
    reply_t              final_reply;
    bit                  keep_going;
    if (sem_closed) begin
      replies_due.push_back(reply_t'{KIND_STATUS, tid, CODE_CLOSED, 1'b0});
    end else begin
      case (cmd)
        CMD_WAIT: begin
          if (blocked_waiters.size() == 0 && avail_units >= units) begin
            avail_units = avail_units - units;
            replies_due.push_back(reply_t'{KIND_STATUS, tid, CODE_OK, 1'b0});
          end else if (blocked_waiters.size() >= QUEUE_DEPTH) begin
            replies_due.push_back(reply_t'{KIND_STATUS, tid, CODE_FULL, 1'b0});
          end else begin
            blocked_waiters.push_back(waiter_t'{tid, units});
            replies_due.push_back(reply_t'{KIND_STATUS, tid, CODE_BLOCKED, 1'b0});
          end
        end
        CMD_SIGNAL_ONE, CMD_SIGNAL_COUNT: begin
          replies_due.push_back(reply_t'{KIND_STATUS, tid, CODE_OK, 1'b0});
          // add units, saturating at the top of the count
          sum = {1'b0, avail_units} +
                ((cmd == CMD_SIGNAL_ONE) ? (COUNT_BITS + 1)'(1) : (COUNT_BITS + 1)'(units));
          if (sum > COUNT_MAX) avail_units = COUNT_MAX[COUNT_BITS-1:0];
          else avail_units = sum[COUNT_BITS-1:0];
          // release from the head while the request fits, only the head for signal one
          keep_going = 1'b1;
          while (keep_going && blocked_waiters.size() != 0 &&
                 blocked_waiters[0].units <= avail_units) begin
            head = blocked_waiters.pop_front();
            avail_units = avail_units - head.units;
            replies_due.push_back(reply_t'{KIND_WAKE, head.tid, CODE_OK, 1'b0});
            keep_going = (cmd == CMD_SIGNAL_COUNT);
          end
        end
        default: begin
          // close: wake everybody with the closed error
          sem_closed = 1'b1;
          replies_due.push_back(reply_t'{KIND_STATUS, tid, CODE_OK, 1'b0});
          while (blocked_waiters.size() != 0) begin
            head = blocked_waiters.pop_front();
            replies_due.push_back(reply_t'{KIND_WAKE, head.tid, CODE_CLOSED, 1'b0});
          end
        end
      endcase
    end
    final_reply = replies_due.pop_back();
    final_reply.last = 1'b1;
    replies_due.push_back(final_reply);
  endtask

  // compare one output transfer against the oldest expected reply
  task automatic check_reply(input reply_t got);
    reply_t want;
    if (replies_due.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: unexpected result kind %0d thread %0d code %0d last %0d",
                 $realtime, got.kind, got.tid, got.code, got.last);
    end else begin
      want = replies_due.pop_front();
      if (got.kind !== want.kind || got.tid !== want.tid ||
          got.code !== want.code || got.last !== want.last) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: mismatch expected kind %0d thread %0d code %0d last %0d, %s",
                   $realtime, want.kind, want.tid, want.code, want.last,
                   $sformatf("got kind %0d thread %0d code %0d last %0d",
                             got.kind, got.tid, got.code, got.last));
      end
    end
  endtask

  // sample both channels and the register port at every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_units = '0;
      sem_closed  = 1'b0;
      blocked_waiters.delete();
      replies_due.delete();
    end else begin
      if (cfg_we_i) avail_units = COUNT_BITS'(cfg_wdata_i);
      if (in_valid_i && !in_stall_i)
        predict_replies(wfs_cmd_e'(in_cmd_i), in_thread_id_i, in_count_i);
      if (out_valid_i && !out_stall_i)
        check_reply(reply_t'{out_kind_i, out_target_thread_i,
                             wfs_code_e'(out_code_i), out_last_i});
    end
    pending_o <= replies_due.size();
    errors_o  <= fail_count;
  end

endmodule

// ===== verif/tb.sv =====
// testbench top for the weighted fifo semaphore: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb;
  import wfs_pkg::*;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_e;

  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 14;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_BITS-1:0]   cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [CMD_BITS-1:0]   in_cmd_i       = CMD_WAIT;
  logic [TID_BITS-1:0]   in_thread_id_i = '0;
  logic [CNT_BITS-1:0]   in_count_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic                  out_kind_o;
  logic [TID_BITS-1:0]   out_target_thread_o;
  logic [CODE_BITS-1:0]  out_code_o;
  logic                  out_last_o;
  int                    pending;
  int                    errors;

  int                    burst_left  = 0;
  stall_style_e          stall_style = STALL_NONE;
  int                    stall_left  = 0;

  // clock, period 4 ns
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  weighted_fifo_semaphore uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_cmd_i            (in_cmd_i),
    .in_thread_id_i      (in_thread_id_i),
    .in_count_i          (in_count_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_kind_o          (out_kind_o),
    .out_target_thread_o (out_target_thread_o),
    .out_code_o          (out_code_o),
    .out_last_o          (out_last_o)
  );

  wfs_checker reply_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .in_cmd_i            (in_cmd_i),
    .in_thread_id_i      (in_thread_id_i),
    .in_count_i          (in_count_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_kind_i          (out_kind_o),
    .out_target_thread_i (out_target_thread_o),
    .out_code_i          (out_code_o),
    .out_last_i          (out_last_o),
    .pending_o           (pending),
    .errors_o            (errors)
  );

  // receiver stall pattern in one of four randomly chosen styles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_style <= stall_style_e'($urandom_range(0, 3));
        stall_left  <= $urandom_range(8, 64);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_style)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_COIN:  out_stall_i <= ($urandom_range(0, 1) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 4) != 0);
        default:     out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  // one command transfer, in bursts with random gaps between them
  task automatic send_command(input wfs_cmd_e cmd, input logic [TID_BITS-1:0] tid,
                              input logic [CNT_BITS-1:0] units);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    in_cmd_i       <= cmd;
    in_thread_id_i <= tid;
    in_count_i     <= units;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only once the block is idle
  task automatic load_count(input logic [CFG_BITS-1:0] value);
    drain();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // random wait or signal, mostly small counts so waiters pile up
  task automatic send_random_command();
    wfs_cmd_e            cmd;
    logic [CNT_BITS-1:0] units;
    int                  pick;
    pick = $urandom_range(0, 9);
    cmd = (pick < 5) ? CMD_WAIT : (pick < 7) ? CMD_SIGNAL_ONE : CMD_SIGNAL_COUNT;
    pick = $urandom_range(0, 9);
    units = (pick < 6) ? CNT_BITS'($urandom_range(0, 4)) :
            (pick < 9) ? CNT_BITS'($urandom) : '1;
    send_command(cmd, TID_BITS'($urandom), units);
  endtask

  // stimulus and verdict
  initial begin
    logic [CFG_BITS-1:0] phase_value;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty semaphore: zero wait, blocking, head release by both signals
    load_count('0);
    send_command(CMD_WAIT, 8'd0, 16'd0);
    send_command(CMD_WAIT, 8'd255, 16'hFFFF);
    send_command(CMD_SIGNAL_ONE, 8'd1, 16'hFFFF);
    send_command(CMD_WAIT, 8'd2, 16'd1);
    send_command(CMD_SIGNAL_COUNT, 8'd3, 16'hFFFF);
    send_command(CMD_WAIT, 8'd4, 16'd1);
    send_command(CMD_SIGNAL_ONE, 8'd9, 16'd0);

    // full count: saturation on both signals, largest wait passes
    load_count('1);
    send_command(CMD_SIGNAL_COUNT, 8'd5, 16'hFFFF);
    send_command(CMD_SIGNAL_ONE, 8'd6, 16'h5A5A);
    send_command(CMD_WAIT, 8'd7, 16'hFFFF);

    // random phases over several starting counts
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       phase_value = '0;
        1:       phase_value = $urandom;
        2:       phase_value = '1;
        3:       phase_value = $urandom_range(0, 64);
        default: phase_value = $urandom_range(0, 8);
      endcase
      load_count(phase_value);
      repeat (PHASE_ITEMS) send_random_command();
    end

    // fill the queue, overflow it, then close with every waiter queued
    load_count('0);
    repeat (QUEUE_DEPTH + 1)
      send_command(CMD_WAIT, TID_BITS'($urandom), CNT_BITS'($urandom_range(1, 65535)));
    send_command(CMD_CLOSE, TID_BITS'($urandom), CNT_BITS'($urandom));
    send_command(CMD_WAIT, TID_BITS'($urandom), 16'd0);
    send_command(CMD_SIGNAL_COUNT, TID_BITS'($urandom), CNT_BITS'($urandom));

    drain();
    repeat (16) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wfs_pkg.sv
rtl/wfs_ram.sv
rtl/wfs_datapath.sv
rtl/wfs_ctrl.sv
rtl/weighted_fifo_semaphore.sv
verif/wfs_checker.sv
verif/tb.sv
